// ===== hw/rtl/cam128_pkg.sv =====
// Package for the Camellia-128 encryption unit: S-box, F function, FL layers,
// key schedule helpers and shared types. No dependencies.
package cam128_pkg;

   localparam int unsigned WordWidth = 128;
   localparam int unsigned HalfWidth = 64;
   localparam int unsigned NumRounds = 18;
   localparam int unsigned NumStages = 19;

   typedef logic [63:0] half_type;

   typedef enum logic {
      CSR_KEY_HIGH = 1'b0,
      CSR_KEY_LOW  = 1'b1
   } csr_index_type;

   // Keys needed by one cell: the Feistel key, and FL keys (used when FlEnable is set).
   typedef struct packed {
      half_type k;
      half_type ke_l;
      half_type ke_r;
   } cell_key_type;

   typedef logic [7:0] sbox_rom_type [256];

   localparam sbox_rom_type Sbox1 = '{
      8'd112,8'd130,8'd44,8'd236,8'd179,8'd39,8'd192,8'd229,8'd228,8'd133,8'd87,8'd53,
      8'd234,8'd12,8'd174,8'd65,8'd35,8'd239,8'd107,8'd147,8'd69,8'd25,8'd165,8'd33,
      8'd237,8'd14,8'd79,8'd78,8'd29,8'd101,8'd146,8'd189,8'd134,8'd184,8'd175,8'd143,
      8'd124,8'd235,8'd31,8'd206,8'd62,8'd48,8'd220,8'd95,8'd94,8'd197,8'd11,8'd26,
      8'd166,8'd225,8'd57,8'd202,8'd213,8'd71,8'd93,8'd61,8'd217,8'd1,8'd90,8'd214,
      8'd81,8'd86,8'd108,8'd77,8'd139,8'd13,8'd154,8'd102,8'd251,8'd204,8'd176,8'd45,
      8'd116,8'd18,8'd43,8'd32,8'd240,8'd177,8'd132,8'd153,8'd223,8'd76,8'd203,8'd194,
      8'd52,8'd126,8'd118,8'd5,8'd109,8'd183,8'd169,8'd49,8'd209,8'd23,8'd4,8'd215,
      8'd20,8'd88,8'd58,8'd97,8'd222,8'd27,8'd17,8'd28,8'd50,8'd15,8'd156,8'd22,
      8'd83,8'd24,8'd242,8'd34,8'd254,8'd68,8'd207,8'd178,8'd195,8'd181,8'd122,8'd145,
      8'd36,8'd8,8'd232,8'd168,8'd96,8'd252,8'd105,8'd80,8'd170,8'd208,8'd160,8'd125,
      8'd161,8'd137,8'd98,8'd151,8'd84,8'd91,8'd30,8'd149,8'd224,8'd255,8'd100,8'd210,
      8'd16,8'd196,8'd0,8'd72,8'd163,8'd247,8'd117,8'd219,8'd138,8'd3,8'd230,8'd218,
      8'd9,8'd63,8'd221,8'd148,8'd135,8'd92,8'd131,8'd2,8'd205,8'd74,8'd144,8'd51,
      8'd115,8'd103,8'd246,8'd243,8'd157,8'd127,8'd191,8'd226,8'd82,8'd155,8'd216,8'd38,
      8'd200,8'd55,8'd198,8'd59,8'd129,8'd150,8'd111,8'd75,8'd19,8'd190,8'd99,8'd46,
      8'd233,8'd121,8'd167,8'd140,8'd159,8'd110,8'd188,8'd142,8'd41,8'd245,8'd249,8'd182,
      8'd47,8'd253,8'd180,8'd89,8'd120,8'd152,8'd6,8'd106,8'd231,8'd70,8'd113,8'd186,
      8'd212,8'd37,8'd171,8'd66,8'd136,8'd162,8'd141,8'd250,8'd114,8'd7,8'd185,8'd85,
      8'd248,8'd238,8'd172,8'd10,8'd54,8'd73,8'd42,8'd104,8'd60,8'd56,8'd241,8'd164,
      8'd64,8'd40,8'd211,8'd123,8'd187,8'd201,8'd67,8'd193,8'd21,8'd227,8'd173,8'd244,
      8'd119,8'd199,8'd128,8'd158
   };

   localparam half_type Sigma1 = 64'hA09E667F3BCC908B;
   localparam half_type Sigma2 = 64'hB67AE8584CAA73B2;
   localparam half_type Sigma3 = 64'hC6EF372FE94F82BE;
   localparam half_type Sigma4 = 64'h54FF53A5F1D36F1C;

   function automatic logic [7:0] rotl8(input logic [7:0] v, input int unsigned n);
      rotl8 = (v << n) | (v >> (8 - n));
   endfunction

   function automatic half_type feistel_f(input half_type din, input half_type key);
      half_type   x;
      logic [7:0] t [8];
      logic [7:0] y [8];
      x = din ^ key;
      for (int i = 0; i < 8; i++) begin
         t[i] = x[63 - 8 * i -: 8];
      end
      t[0] = Sbox1[t[0]];
      t[1] = rotl8(Sbox1[t[1]], 1);
      t[2] = rotl8(Sbox1[t[2]], 7);
      t[3] = Sbox1[rotl8(t[3], 1)];
      t[4] = rotl8(Sbox1[t[4]], 1);
      t[5] = rotl8(Sbox1[t[5]], 7);
      t[6] = Sbox1[rotl8(t[6], 1)];
      t[7] = Sbox1[t[7]];
      y[0] = t[0] ^ t[2] ^ t[3] ^ t[5] ^ t[6] ^ t[7];
      y[1] = t[0] ^ t[1] ^ t[3] ^ t[4] ^ t[6] ^ t[7];
      y[2] = t[0] ^ t[1] ^ t[2] ^ t[4] ^ t[5] ^ t[7];
      y[3] = t[1] ^ t[2] ^ t[3] ^ t[4] ^ t[5] ^ t[6];
      y[4] = t[0] ^ t[1] ^ t[5] ^ t[6] ^ t[7];
      y[5] = t[1] ^ t[2] ^ t[4] ^ t[6] ^ t[7];
      y[6] = t[2] ^ t[3] ^ t[4] ^ t[5] ^ t[7];
      y[7] = t[0] ^ t[3] ^ t[4] ^ t[5] ^ t[6];
      feistel_f = {y[0], y[1], y[2], y[3], y[4], y[5], y[6], y[7]};
   endfunction

   function automatic logic [31:0] rotl32_1(input logic [31:0] v);
      rotl32_1 = {v[30:0], v[31]};
   endfunction

   function automatic half_type layer_fl(input half_type x, input half_type k);
      logic [31:0] x1, x2;
      x1 = x[63:32];
      x2 = x[31:0];
      x2 = x2 ^ rotl32_1(x1 & k[63:32]);
      x1 = x1 ^ (x2 | k[31:0]);
      layer_fl = {x1, x2};
   endfunction

   function automatic half_type layer_fl_inv(input half_type y, input half_type k);
      logic [31:0] y1, y2;
      y1 = y[63:32];
      y2 = y[31:0];
      y1 = y1 ^ (y2 | k[31:0]);
      y2 = y2 ^ rotl32_1(y1 & k[63:32]);
      layer_fl_inv = {y1, y2};
   endfunction

   // 128-bit left rotation by a constant amount.
   function automatic logic [127:0] rot128(input logic [127:0] v, input int unsigned n);
      rot128 = (n == 0) ? v : ((v << n) | (v >> (128 - n)));
   endfunction

endpackage

// ===== hw/rtl/camellia_128_block_encrypt_unit.sv =====
// Camellia-128 block encryption unit: 18 round cells in a chain.
// Each accepted plaintext word passes the input whitening register, 18 round
// cells and the output register on its way to the ciphertext word.
// Throughput: one word per cycle while req_tready is high; the whole chain stalls
// when the output is held. Reset (synchronous, active high) empties the chain and
// loads the zero key; the schedule that follows it or a key write holds req_tready low.
module camellia_128_block_encrypt_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,  // plain_high [63:0], plain_low [127:64]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,  // cipher_high [63:0], cipher_low [127:64]
   input  logic         csr_tvalid,
   output logic         csr_tready,
   input  logic [0:0]   csr_index,
   input  logic [63:0]  csr_data
);
   import cam128_pkg::*;

   // The key schedule module holds the 26 subkeys. Each plaintext word is
   // whitened into an entry register, walks through the chain of round cells
   // (FL layers fused into the sixth and twelfth cells) and is post-whitened
   // into the output register.

   half_type kw [4];
   half_type k [18];
   half_type ke [4];
   logic     ks_busy;
   logic     advance;
   logic     csr_write;

   // Configuration is taken at any time; the block is assumed idle then.
   assign csr_tready = 1'b1;
   assign csr_write  = csr_tvalid && csr_index <= 1'b1;

   cam128_keysched u_keysched (
      .clock      (clock),
      .reset      (reset),
      .csr_tvalid (csr_write),
      .csr_index  (csr_index[0]),
      .csr_data   (csr_data),
      .kw_ff_out  (kw),
      .k_out      (k),
      .ke_out     (ke),
      .busy       (ks_busy)
   );

   // The chain moves whenever the output register is free or being emptied.
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance && !ks_busy;

   logic         entry_valid_ff;
   logic [127:0] entry_data_ff;
   logic         valid_chain [NumRounds + 1];
   logic [127:0] data_chain [NumRounds + 1];

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
      end else if (advance) begin
         entry_valid_ff <= req_tvalid && req_tready;
      end
      if (advance) begin
         entry_data_ff <= {req_tdata[63:0] ^ kw[0], req_tdata[127:64] ^ kw[1]};
      end
   end

   assign valid_chain[0] = entry_valid_ff;
   assign data_chain[0]  = entry_data_ff;

   for (genvar g = 0; g < NumRounds; g++) begin : g_cell
      cell_key_type ck;
      assign ck.k    = k[g];
      assign ck.ke_l = (g < 6) ? ke[0] : ke[2];
      assign ck.ke_r = (g < 6) ? ke[1] : ke[3];
      cam128_cell #(
         .FlEnable ((g == 5) || (g == 11))
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .valid_in (valid_chain[g]),
         .data_in  (data_chain[g]),
         .keys     (ck),
         .valid_ff (valid_chain[g + 1]),
         .data_ff  (data_chain[g + 1])
      );
   end

   logic         out_valid_ff;
   logic [127:0] out_data_ff;
   half_type     fin_d1, fin_d2;

   // After an even number of rounds the halves stand in order: {d1, d2}.
   // The final swap puts d2 into the upper ciphertext half.
   assign fin_d1 = data_chain[NumRounds][127:64];
   assign fin_d2 = data_chain[NumRounds][63:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= valid_chain[NumRounds];
      end
      if (advance) begin
         out_data_ff <= {fin_d1 ^ kw[3], fin_d2 ^ kw[2]};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata))
      else $error("stalled result changed");
   assert property (@(posedge clock) disable iff (reset)
      ks_busy |-> !req_tready)
      else $error("word accepted during key schedule");
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(valid_chain[NumRounds]))
      else $error("chain moved while stalled");
endmodule

// ===== hw/rtl/cam128_keysched.sv =====
// Camellia-128 key schedule: computes KA from the configured key over four
// registered F steps and holds all 26 subkeys. Depends on cam128_pkg.
module cam128_keysched (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_tvalid,
   input  logic                  csr_index,
   input  cam128_pkg::half_type  csr_data,
   output cam128_pkg::half_type  kw_ff_out [4],
   output cam128_pkg::half_type  k_out [18],
   output cam128_pkg::half_type  ke_out [4],
   output logic                  busy
);
   import cam128_pkg::*;

   half_type   key_high_ff, key_high_in, key_low_ff, key_low_in;
   half_type   d1_ff, d1_in, d2_ff, d2_in;
   logic [2:0] step_ff, step_in;
   logic [127:0] ka_ff, ka_in;
   logic [127:0] kl;

   // step: 0 idle; 1..4 F computations; reset restarts the schedule.
   always_comb begin
      key_high_in = key_high_ff;
      key_low_in  = key_low_ff;
      d1_in = d1_ff;
      d2_in = d2_ff;
      step_in = step_ff;
      ka_in = ka_ff;
      if (csr_tvalid) begin
         if (csr_index == CSR_KEY_HIGH) begin
            key_high_in = csr_data;
         end else begin
            key_low_in = csr_data;
         end
         step_in = 3'd1;
      end else begin
         case (step_ff)
            3'd1: begin
               d1_in = key_high_ff;
               d2_in = key_low_ff ^ feistel_f(key_high_ff, Sigma1);
               step_in = 3'd2;
            end
            3'd2: begin
               d1_in = d1_ff ^ feistel_f(d2_ff, Sigma2) ^ key_high_ff;
               d2_in = d2_ff ^ key_low_ff;
               step_in = 3'd3;
            end
            3'd3: begin
               d2_in = d2_ff ^ feistel_f(d1_ff, Sigma3);
               step_in = 3'd4;
            end
            3'd4: begin
               ka_in = {d1_ff ^ feistel_f(d2_ff, Sigma4), d2_ff};
               step_in = 3'd0;
            end
            default: step_in = 3'd0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
         step_ff     <= 3'd1;
      end else begin
         key_high_ff <= key_high_in;
         key_low_ff  <= key_low_in;
         step_ff     <= step_in;
      end
      d1_ff <= d1_in;
      d2_ff <= d2_in;
      ka_ff <= ka_in;
   end

   assign busy = (step_ff != 3'd0);
   assign kl = {key_high_ff, key_low_ff};

   logic [127:0] r_kl15, r_ka15, r_ka30, r_kl45, r_ka45, r_kl60, r_ka60;
   logic [127:0] r_kl77, r_kl94, r_ka94, r_kl111, r_ka111;
   assign r_kl15  = rot128(kl, 15);
   assign r_ka15  = rot128(ka_ff, 15);
   assign r_ka30  = rot128(ka_ff, 30);
   assign r_kl45  = rot128(kl, 45);
   assign r_ka45  = rot128(ka_ff, 45);
   assign r_kl60  = rot128(kl, 60);
   assign r_ka60  = rot128(ka_ff, 60);
   assign r_kl77  = rot128(kl, 77);
   assign r_kl94  = rot128(kl, 94);
   assign r_ka94  = rot128(ka_ff, 94);
   assign r_kl111 = rot128(kl, 111);
   assign r_ka111 = rot128(ka_ff, 111);

   assign kw_ff_out[0] = key_high_ff;
   assign kw_ff_out[1] = key_low_ff;
   assign kw_ff_out[2] = r_ka111[127:64];
   assign kw_ff_out[3] = r_ka111[63:0];
   assign k_out[0]  = ka_ff[127:64];
   assign k_out[1]  = ka_ff[63:0];
   assign k_out[2]  = r_kl15[127:64];
   assign k_out[3]  = r_kl15[63:0];
   assign k_out[4]  = r_ka15[127:64];
   assign k_out[5]  = r_ka15[63:0];
   assign k_out[6]  = r_kl45[127:64];
   assign k_out[7]  = r_kl45[63:0];
   assign k_out[8]  = r_ka45[127:64];
   assign k_out[9]  = r_kl60[63:0];
   assign k_out[10] = r_ka60[127:64];
   assign k_out[11] = r_ka60[63:0];
   assign k_out[12] = r_kl94[127:64];
   assign k_out[13] = r_kl94[63:0];
   assign k_out[14] = r_ka94[127:64];
   assign k_out[15] = r_ka94[63:0];
   assign k_out[16] = r_kl111[127:64];
   assign k_out[17] = r_kl111[63:0];
   assign ke_out[0] = r_ka30[127:64];
   assign ke_out[1] = r_ka30[63:0];
   assign ke_out[2] = r_kl77[127:64];
   assign ke_out[3] = r_kl77[63:0];

   // A key write always starts a fresh schedule computation.
   assert property (@(posedge clock) disable iff (reset)
      csr_tvalid |=> step_ff == 3'd1)
      else $error("key write did not restart schedule");
   assert property (@(posedge clock) disable iff (reset)
      (step_ff == 3'd4 && !csr_tvalid) |=> !busy)
      else $error("schedule did not finish");
   assert property (@(posedge clock) disable iff (reset)
      $past(csr_tvalid) == 1'b0 && !csr_tvalid |-> $stable(kl))
      else $error("key changed without a write");
endmodule

// ===== hw/rtl/cam128_cell.sv =====
// One Camellia round cell: a Feistel round, optionally followed by the FL and
// FL-inverse layer, registered with its valid bit. Depends on cam128_pkg.
module cam128_cell #(
   parameter bit FlEnable = 1'b0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic                      valid_in,
   input  logic [127:0]              data_in,
   input  cam128_pkg::cell_key_type  keys,
   output logic                      valid_ff,
   output logic [127:0]              data_ff
);
   import cam128_pkg::*;

   half_type     d1, d2n;
   logic [127:0] data_in_c;
   logic         valid_in_c;

   // Data is {d1,d2}; a round computes d2 ^= F(d1) and swaps the halves.
   always_comb begin
      d1  = data_in[127:64];
      d2n = data_in[63:0] ^ feistel_f(d1, keys.k);
      if (FlEnable) begin
         data_in_c = {layer_fl(d2n, keys.ke_l), layer_fl_inv(d1, keys.ke_r)};
      end else begin
         data_in_c = {d2n, d1};
      end
      valid_in_c = valid_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in_c;
      end
      if (advance) begin
         data_ff <= data_in_c;
      end
   end
endmodule
